// ===== rtl/alc_pkg.sv =====
// ---------------------------------------------------------------------------
// ARQ link controller package
// Shared constants, codes and types of the stop-and-wait link controller.
// ---------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int HANDLE_W = 8;
  localparam int ID_W = 2;
  localparam int ENTRY_W = HANDLE_W + ID_W;
  localparam int RETRY_W = 4;
  localparam int RXID_W = 3;

  localparam logic [RXID_W-1:0] NO_ID = 3'd4;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd15;

  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_ACK  = 2'd2;
  localparam logic [1:0] ACT_DATA = 2'd3;

  localparam logic [2:0] KIND_TX_DATA = 3'd0;
  localparam logic [2:0] KIND_TX_ACK  = 3'd1;
  localparam logic [2:0] KIND_SUCCESS = 3'd2;
  localparam logic [2:0] KIND_FAILED  = 3'd3;
  localparam logic [2:0] KIND_READY   = 3'd4;
  localparam logic [2:0] KIND_FULL    = 3'd5;
  localparam logic [2:0] KIND_INVALID = 3'd6;

  localparam logic REG_LINK_MODE   = 1'b0;
  localparam logic REG_RETRY_LIMIT = 1'b1;

  typedef struct packed {
    logic               link_mode;
    logic [RETRY_W-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    logic                last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/arq_link_controller_top.sv =====
// ---------------------------------------------------------------------------
// ARQ link controller
// Stop-and-wait link controller with a 2-bit packet ID and a packet queue.
// ---------------------------------------------------------------------------
// Events enter on the in_ stream: tuser carries the event kind (send request,
// retry tick, ack received, data packet received), tdata the buffer handle in
// bits 7..0 and the received packet ID in bits 9..8. Results leave on the
// out_ stream: tuser carries the result kind, tdata the handle in bits 7..0
// and the packet ID in bits 9..8, and tlast marks the final result of an
// event. An event causes zero, one or two results.
// The block takes one event at a time; an event with no result leaves it
// ready for the next. Otherwise the first result follows in the cycle after
// acceptance, and results leave one per cycle while out_tready is high; a
// completion that starts the next queued packet first passes the fetch
// state to read the queue memory. in_tready stays low while results are
// pending, so a stalled receiver holds back the input. Configuration writes
// are registered; the user makes them while the block is idle, which the
// block does not enforce. Reset selects the receiver role, a retry limit of
// 15, an empty queue and no last received ID; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module arq_link_controller_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [1:0]  in_tuser,   // action
  input  wire logic [15:0] in_tdata,   // handle, rx_id, zero fill
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [2:0]  out_tuser,  // kind
  output      logic [15:0] out_tdata,  // out_handle, out_id, zero fill
  output      logic        out_tlast
);

  alc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        alc_pkg::REG_LINK_MODE:   cfg_nxt.link_mode = cfg_wdata[0];
        alc_pkg::REG_RETRY_LIMIT: cfg_nxt.retry_limit = cfg_wdata;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{link_mode: 1'b0, retry_limit: alc_pkg::RETRY_LIMIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  alc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/alc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module alc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/alc_core.sv =====
// ---------------------------------------------------------------------------
// ARQ link controller core
// Event sequencer around the packet queue memory, with a two-entry
// result buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module alc_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire alc_pkg::cfg_t cfg,
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [1:0]    in_tuser,
  input  wire logic [15:0]   in_tdata,
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [2:0]    out_tuser,
  output      logic [15:0]   out_tdata,
  output      logic          out_tlast
);

  localparam logic [alc_pkg::PTR_W-1:0] PTR_LAST =
    alc_pkg::PTR_W'(alc_pkg::QUEUE_DEPTH - 1);
  localparam logic [alc_pkg::CNT_W-1:0] CNT_FULL =
    alc_pkg::CNT_W'(alc_pkg::QUEUE_DEPTH);

  alc_pkg::state_t state_r, state_nxt;
  logic [alc_pkg::PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [alc_pkg::PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [alc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [alc_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic                        in_flight_r, in_flight_nxt;
  logic [alc_pkg::ENTRY_W-1:0] cur_r, cur_nxt;
  logic [alc_pkg::RETRY_W-1:0] retries_r, retries_nxt;
  logic [alc_pkg::RXID_W-1:0]  last_rx_r, last_rx_nxt;
  alc_pkg::res_t               res0_r, res0_nxt, res1_r, res1_nxt;
  logic                        two_r, two_nxt;
  logic                        idx_r, idx_nxt;

  logic                        ram_we;
  logic [alc_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [alc_pkg::ENTRY_W-1:0] ram_rdata;

  logic                         accept;
  logic [alc_pkg::HANDLE_W-1:0] hdl;
  logic [alc_pkg::ID_W-1:0]     rid;
  alc_pkg::res_t                res_out;

  assign hdl = in_tdata[alc_pkg::HANDLE_W-1:0];
  assign rid = in_tdata[alc_pkg::HANDLE_W +: alc_pkg::ID_W];
  assign in_tready = (state_r == alc_pkg::ST_IDLE);
  assign accept = in_tvalid && in_tready;

  assign res_out    = idx_r ? res1_r : res0_r;
  assign out_tvalid = (state_r == alc_pkg::ST_DRAIN);
  assign out_tuser  = res_out.kind;
  assign out_tdata  = {6'd0, res_out.id, res_out.handle};
  assign out_tlast  = res_out.last;

  alc_ram #(
    .WIDTH(alc_pkg::ENTRY_W),
    .DEPTH(alc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    cnt_nxt       = cnt_r;
    next_id_nxt   = next_id_r;
    in_flight_nxt = in_flight_r;
    cur_nxt       = cur_r;
    retries_nxt   = retries_r;
    last_rx_nxt   = last_rx_r;
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    two_nxt       = two_r;
    idx_nxt       = idx_r;
    ram_we        = 1'b0;
    ram_wdata     = {hdl, next_id_r};
    ram_re        = 1'b0;

    case (state_r)
      alc_pkg::ST_IDLE: begin
        if (accept) begin
          res0_nxt = '{kind: alc_pkg::KIND_INVALID, handle: '0, id: '0, last: 1'b1};
          res1_nxt = '{kind: alc_pkg::KIND_TX_DATA, handle: '0, id: '0, last: 1'b1};
          two_nxt  = 1'b0;
          idx_nxt  = 1'b0;
          case (in_tuser)
            alc_pkg::ACT_SEND: begin
              if (!cfg.link_mode) begin
                state_nxt = alc_pkg::ST_DRAIN;
              end else begin
                next_id_nxt = next_id_r + 1'b1;
                if (cnt_r == CNT_FULL) begin
                  res0_nxt.kind = alc_pkg::KIND_FULL;
                  state_nxt = alc_pkg::ST_DRAIN;
                end else begin
                  ram_we     = 1'b1;
                  wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
                  cnt_nxt    = cnt_r + 1'b1;
                  if (!in_flight_r) begin
                    cur_nxt       = {hdl, next_id_r};
                    rd_ptr_nxt    = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
                    in_flight_nxt = 1'b1;
                    retries_nxt   = '0;
                    res0_nxt      = '{kind: alc_pkg::KIND_TX_DATA, handle: hdl,
                                      id: next_id_r, last: 1'b1};
                    state_nxt     = alc_pkg::ST_DRAIN;
                  end
                end
              end
            end
            alc_pkg::ACT_TICK, alc_pkg::ACT_ACK: begin
              if (cfg.link_mode && in_flight_r) begin
                if ((in_tuser == alc_pkg::ACT_TICK) && (retries_r < cfg.retry_limit)) begin
                  res0_nxt = '{kind: alc_pkg::KIND_TX_DATA,
                               handle: cur_r[alc_pkg::ID_W +: alc_pkg::HANDLE_W],
                               id: cur_r[alc_pkg::ID_W-1:0], last: 1'b1};
                  retries_nxt = retries_r + 1'b1;
                  state_nxt   = alc_pkg::ST_DRAIN;
                end else begin
                  res0_nxt.kind = (in_tuser == alc_pkg::ACT_TICK) ?
                                  alc_pkg::KIND_FAILED : alc_pkg::KIND_SUCCESS;
                  in_flight_nxt = 1'b0;
                  retries_nxt   = '0;
                  if (cnt_r != '0) begin
                    cnt_nxt = cnt_r - 1'b1;
                  end
                  if (cnt_r > alc_pkg::CNT_W'(1)) begin
                    res0_nxt.last = 1'b0;
                    two_nxt       = 1'b1;
                    ram_re        = 1'b1;
                    state_nxt     = alc_pkg::ST_FETCH;
                  end else begin
                    state_nxt = alc_pkg::ST_DRAIN;
                  end
                end
              end
            end
            default: begin
              if (!cfg.link_mode) begin
                res0_nxt.kind = alc_pkg::KIND_TX_ACK;
                if ({1'b0, rid} != last_rx_r) begin
                  last_rx_nxt   = {1'b0, rid};
                  res0_nxt.last = 1'b0;
                  res1_nxt      = '{kind: alc_pkg::KIND_READY, handle: hdl,
                                    id: '0, last: 1'b1};
                  two_nxt       = 1'b1;
                end
                state_nxt = alc_pkg::ST_DRAIN;
              end
            end
          endcase
        end
      end
      alc_pkg::ST_FETCH: begin
        cur_nxt       = ram_rdata;
        rd_ptr_nxt    = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
        in_flight_nxt = 1'b1;
        retries_nxt   = '0;
        res1_nxt      = '{kind: alc_pkg::KIND_TX_DATA,
                          handle: ram_rdata[alc_pkg::ID_W +: alc_pkg::HANDLE_W],
                          id: ram_rdata[alc_pkg::ID_W-1:0], last: 1'b1};
        state_nxt     = alc_pkg::ST_DRAIN;
      end
      alc_pkg::ST_DRAIN: begin
        if (out_tready) begin
          if (two_r && !idx_r) begin
            idx_nxt = 1'b1;
          end else begin
            idx_nxt   = 1'b0;
            state_nxt = alc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = alc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alc_pkg::ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      next_id_r   <= '0;
      in_flight_r <= 1'b0;
      cur_r       <= '0;
      retries_r   <= '0;
      last_rx_r   <= alc_pkg::NO_ID;
      two_r       <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cnt_r       <= cnt_nxt;
      next_id_r   <= next_id_nxt;
      in_flight_r <= in_flight_nxt;
      cur_r       <= cur_nxt;
      retries_r   <= retries_nxt;
      last_rx_r   <= last_rx_nxt;
      two_r       <= two_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result channels active together");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count above depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alc_pkg::ST_IDLE && !in_flight_r) |-> (cnt_r == '0))
    else $error("packets queued with nothing in flight");

  a_fetch_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alc_pkg::ST_FETCH) |=> (state_r == alc_pkg::ST_DRAIN && two_r))
    else $error("queue fetch not followed by a two-result drain");

endmodule

`default_nettype wire

// ===== bench/arq_link_checker.sv =====
// ---------------------------------------------------------------------------
// ARQ link controller checker
// Watches the configuration port and both streams of the link controller,
// predicts the results of every accepted event and compares each result
// transfer, field by field, against the oldest predicted result.
// ---------------------------------------------------------------------------
module arq_link_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [15:0] in_tdata,   // handle, rx_id, zero fill
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [2:0]  out_tuser,  // kind
  input  logic [15:0] out_tdata,  // out_handle, out_id, zero fill
  input  logic        out_tlast,
  output int          results_pending,
  output int          mismatch_count
);

  logic                         tx_role;
  logic [alc_pkg::RETRY_W-1:0]  retry_cap;
  logic [alc_pkg::ENTRY_W-1:0]  pkt_fifo [alc_pkg::QUEUE_DEPTH];
  logic [alc_pkg::PTR_W-1:0]    head_ptr;
  logic [alc_pkg::PTR_W-1:0]    tail_ptr;
  logic [alc_pkg::CNT_W-1:0]    pkt_count;
  logic [alc_pkg::ID_W-1:0]     seq_id;
  logic                         pkt_active;
  logic [alc_pkg::ENTRY_W-1:0]  active_pkt;
  logic [alc_pkg::RETRY_W-1:0]  resends;
  logic [alc_pkg::RXID_W-1:0]   last_rx;
  alc_pkg::res_t                results_due [$];
  alc_pkg::res_t                step_out [2];
  int                           step_n;
  int                           errors;

  function automatic logic [alc_pkg::PTR_W-1:0] ptr_inc(logic [alc_pkg::PTR_W-1:0] p);
    if (int'(p) == alc_pkg::QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  task automatic add_result(logic [2:0] kind, logic [alc_pkg::HANDLE_W-1:0] hdl,
                            logic [alc_pkg::ID_W-1:0] id);
    step_out[step_n] = {kind, hdl, id, 1'b0};
    step_n++;
  endtask

  task automatic transmit_active();
    add_result(alc_pkg::KIND_TX_DATA, active_pkt[alc_pkg::ENTRY_W-1:alc_pkg::ID_W],
               active_pkt[alc_pkg::ID_W-1:0]);
  endtask

  task automatic start_queued();
    if (!pkt_active && pkt_count != '0) begin
      active_pkt = pkt_fifo[head_ptr];
      head_ptr = ptr_inc(head_ptr);
      pkt_active = 1'b1;
      resends = '0;
      transmit_active();
    end
  endtask

  task automatic complete_packet(logic [2:0] kind);
    add_result(kind, '0, '0);
    pkt_active = 1'b0;
    resends = '0;
    if (pkt_count != '0) begin
      pkt_count = pkt_count - 1'b1;
    end
    start_queued();
  endtask

  task automatic step_link(logic [1:0] action, logic [alc_pkg::HANDLE_W-1:0] hdl,
                           logic [alc_pkg::ID_W-1:0] rid);
    logic [alc_pkg::ID_W-1:0] new_id;
    alc_pkg::res_t            r;
    step_n = 0;
    case (action)
      alc_pkg::ACT_SEND: begin
        if (!tx_role) begin
          add_result(alc_pkg::KIND_INVALID, '0, '0);
        end else begin
          // A refused request still uses up its packet ID.
          new_id = seq_id;
          seq_id = seq_id + 1'b1;
          if (int'(pkt_count) >= alc_pkg::QUEUE_DEPTH) begin
            add_result(alc_pkg::KIND_FULL, '0, '0);
          end else begin
            pkt_fifo[tail_ptr] = {hdl, new_id};
            tail_ptr = ptr_inc(tail_ptr);
            pkt_count = pkt_count + 1'b1;
            start_queued();
          end
        end
      end
      alc_pkg::ACT_TICK: begin
        if (tx_role && pkt_active) begin
          if (resends >= retry_cap) begin
            complete_packet(alc_pkg::KIND_FAILED);
          end else begin
            transmit_active();
            resends = resends + 1'b1;
          end
        end
      end
      alc_pkg::ACT_ACK: begin
        if (tx_role && pkt_active) begin
          complete_packet(alc_pkg::KIND_SUCCESS);
        end
      end
      default: begin
        if (!tx_role) begin
          add_result(alc_pkg::KIND_TX_ACK, '0, '0);
          if (alc_pkg::RXID_W'(rid) != last_rx) begin
            last_rx = alc_pkg::RXID_W'(rid);
            add_result(alc_pkg::KIND_READY, hdl, '0);
          end
        end
      end
    endcase
    for (int i = 0; i < step_n; i++) begin
      r = step_out[i];
      if (i == step_n - 1) begin
        r.last = 1'b1;
      end
      results_due.push_back(r);
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    alc_pkg::res_t want;
    if (!rst_n) begin
      tx_role = 1'b0;
      retry_cap = alc_pkg::RETRY_LIMIT_RST;
      for (int i = 0; i < alc_pkg::QUEUE_DEPTH; i++) begin
        pkt_fifo[i] = '0;
      end
      head_ptr = '0;
      tail_ptr = '0;
      pkt_count = '0;
      seq_id = '0;
      pkt_active = 1'b0;
      active_pkt = '0;
      resends = '0;
      last_rx = alc_pkg::NO_ID;
      results_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == alc_pkg::REG_LINK_MODE) begin
          tx_role = cfg_wdata[0];
        end else begin
          retry_cap = cfg_wdata;
        end
      end
      if (in_tvalid && in_tready) begin
        step_link(in_tuser, in_tdata[alc_pkg::HANDLE_W-1:0],
                  in_tdata[alc_pkg::HANDLE_W+alc_pkg::ID_W-1:alc_pkg::HANDLE_W]);
      end
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected: expected none, %s %0d %s 0x%04h %s %0b",
                   $time, "got kind", out_tuser, "tdata", out_tdata, "last", out_tlast);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_tuser));
          check_field("handle", want.handle, out_tdata[alc_pkg::HANDLE_W-1:0]);
          check_field("id", 8'(want.id),
                      8'(out_tdata[alc_pkg::HANDLE_W+alc_pkg::ID_W-1:alc_pkg::HANDLE_W]));
          check_field("last", 8'(want.last), 8'(out_tlast));
        end
      end
    end
    results_pending <= results_due.size();
    mismatch_count <= errors;
  end

endmodule

// ===== bench/tb_arq_link_controller_top.sv =====
// ---------------------------------------------------------------------------
// ARQ link controller testbench
// Drives directed and random event streams in both link roles under several
// retry limits, with random stalls on both streams, and leaves the checking
// to a checker module that predicts every result.
// ---------------------------------------------------------------------------
module tb_arq_link_controller_top;

  localparam logic MODE_RX = 1'b0;
  localparam logic MODE_TX = 1'b1;
  localparam int EVENT_TARGET = 1850;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // action
  logic [15:0] in_tdata;   // handle, rx_id, zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;  // kind
  logic [15:0] out_tdata;  // out_handle, out_id, zero fill
  logic        out_tlast;

  int   results_pending;
  int   mismatch_count;
  logic hold_req;
  logic quiet;
  int   stall_pct;
  int   gap_pct;
  int   counted;
  int   cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arq_link_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  arq_link_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tuser       (out_tuser),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .results_pending (results_pending),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [alc_pkg::HANDLE_W-1:0] rand_handle();
    return alc_pkg::HANDLE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [alc_pkg::ID_W-1:0] rand_id();
    return alc_pkg::ID_W'($urandom_range(0, 3));
  endfunction

  task automatic issue_event(logic [1:0] action, logic [alc_pkg::HANDLE_W-1:0] hdl,
                             logic [alc_pkg::ID_W-1:0] rid);
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {{(16 - alc_pkg::HANDLE_W - alc_pkg::ID_W){1'b0}}, rid, hdl};
    do @(posedge clk); while (!in_tready);
    counted++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(logic role, logic [alc_pkg::RETRY_W-1:0] limit);
    cfg_we <= 1'b1;
    cfg_addr <= alc_pkg::REG_LINK_MODE;
    cfg_wdata <= {{(alc_pkg::RETRY_W - 1){1'b0}}, role};
    @(posedge clk);
    cfg_addr <= alc_pkg::REG_RETRY_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_tx_phase(int n_items, bit tick_heavy);
    int pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(3, 6)) issue_event(alc_pkg::ACT_SEND, rand_handle(), rand_id());
      end else if (pick < 28) begin
        issue_event(alc_pkg::ACT_SEND, rand_handle(), rand_id());
      end else if (pick < (tick_heavy ? 88 : 60)) begin
        issue_event(alc_pkg::ACT_TICK, rand_handle(), rand_id());
      end else if (pick < 95) begin
        issue_event(alc_pkg::ACT_ACK, rand_handle(), rand_id());
      end else begin
        issue_event(alc_pkg::ACT_DATA, rand_handle(), rand_id());
      end
    end
  endtask

  task automatic run_rx_phase(int n_items);
    logic [alc_pkg::ID_W-1:0] rid;
    int                       pick;
    rid = rand_id();
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        // Mostly the next ID in turn, some retransmissions of the same ID.
        case ($urandom_range(0, 9)) inside
          [0:5]: rid = rid + 1'b1;
          [6:7]: rid = rid;
          default: rid = rand_id();
        endcase
        issue_event(alc_pkg::ACT_DATA, rand_handle(), rid);
      end else if (pick < 93) begin
        issue_event(alc_pkg::ACT_SEND, rand_handle(), rand_id());
      end else if (pick < 97) begin
        issue_event(alc_pkg::ACT_TICK, rand_handle(), rand_id());
      end else begin
        issue_event(alc_pkg::ACT_ACK, rand_handle(), rand_id());
      end
    end
  endtask

  initial begin
    logic                        role;
    logic [alc_pkg::RETRY_W-1:0] limit;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= alc_pkg::REG_LINK_MODE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser <= alc_pkg::ACT_SEND;
    in_tdata <= '0;
    hold_req <= 1'b0;
    quiet <= 1'b0;
    stall_pct <= 0;
    gap_pct = 0;
    counted = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Receiver role as left by reset.
    issue_event(alc_pkg::ACT_SEND, 8'hFF, 2'd3);
    issue_event(alc_pkg::ACT_TICK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_ACK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_DATA, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_DATA, 8'hFF, 2'd0);
    issue_event(alc_pkg::ACT_DATA, 8'hFF, 2'd3);

    // Transmitter role with no retransmission allowed; the queue overflows.
    settle();
    set_config(MODE_TX, 4'd0);
    issue_event(alc_pkg::ACT_DATA, 8'h5A, 2'd1);
    issue_event(alc_pkg::ACT_TICK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_ACK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_SEND, 8'hFF, 2'd0);
    issue_event(alc_pkg::ACT_SEND, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_SEND, 8'hAA, 2'd0);
    issue_event(alc_pkg::ACT_SEND, 8'h55, 2'd0);
    issue_event(alc_pkg::ACT_SEND, 8'h12, 2'd0);
    issue_event(alc_pkg::ACT_TICK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_ACK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_ACK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_ACK, 8'h00, 2'd0);

    settle();
    set_config(MODE_TX, 4'd1);
    issue_event(alc_pkg::ACT_SEND, 8'h81, 2'd2);
    issue_event(alc_pkg::ACT_TICK, 8'h00, 2'd0);
    issue_event(alc_pkg::ACT_TICK, 8'h00, 2'd0);

    // The receiver holds off while requests keep coming.
    settle();
    set_config(MODE_TX, 4'd3);
    hold_req <= 1'b1;
    repeat (12) issue_event(alc_pkg::ACT_SEND, rand_handle(), rand_id());

    while (counted < EVENT_TARGET) begin
      settle();
      if (counted >= EVENT_TARGET - QUIET_TAIL) begin
        quiet <= 1'b1;
        stall_pct <= 0;
        gap_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: stall_pct <= 0;
          1: stall_pct <= 10;
          default: stall_pct <= 30;
        endcase
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      role = ($urandom_range(0, 2) != 0) ? MODE_TX : MODE_RX;
      case ($urandom_range(0, 5)) inside
        0: limit = 4'd0;
        1: limit = 4'd15;
        [2:3]: limit = alc_pkg::RETRY_W'($urandom_range(1, 3));
        default: limit = alc_pkg::RETRY_W'($urandom_range(0, 15));
      endcase
      set_config(role, limit);
      if (role == MODE_TX) begin
        run_tx_phase($urandom_range(20, 60), limit > 4'd4);
      end else begin
        run_rx_phase($urandom_range(20, 60));
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
